[design/bfifo_pkg.sv]
package bfifo_pkg;

	// Default ring depth and fixed field widths.
	localparam int DEPTH_DEF = 64;
	localparam int VAL_W     = 7;
	localparam int BYTE_W    = 8;
	localparam int CMD_W     = 2;
	localparam int KIND_W    = 2;
	localparam int CFG_IDX_W = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRIGGER  = 2'd1;

	// Reset values of the configuration registers.
	localparam logic [VAL_W-1:0] CAPACITY_RST = 7'd64;
	localparam logic [VAL_W-1:0] TRIGGER_RST  = 7'd1;

	// Input operation codes.
	typedef enum logic [CMD_W-1:0] {
		CMD_SEND  = 2'd0,
		CMD_RECV  = 2'd1,
		CMD_RESET = 2'd2
	} cmd_code_t;

	// Result kinds.
	typedef enum logic [KIND_W-1:0] {
		KIND_SEND  = 2'd0,
		KIND_BYTE  = 2'd1,
		KIND_BELOW = 2'd2,
		KIND_RESET = 2'd3
	} kind_t;

	// Controller states.
	typedef enum logic {
		ST_IDLE,
		ST_DRAIN
	} state_t;

	// Datapath operations issued by the controller.
	typedef enum logic [2:0] {
		OP_NONE,
		OP_SEND,
		OP_BELOW,
		OP_RESET,
		OP_START,
		OP_POP
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;  // output register can take a result this cycle
		logic no_drain;  // a receive now would drain nothing
		logic last_pop;  // the next pop ends the burst
	} dp_status_t;

endpackage

[design/bfifo_ctrl.sv]
module bfifo_ctrl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [bfifo_pkg::CMD_W-1:0]      cmd,
	input  bfifo_pkg::dp_status_t            dp_status,
	output bfifo_pkg::dp_cmd_t               dp_cmd
);
	import bfifo_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && dp_status.out_free && cmd == CMD_RECV && !dp_status.no_drain) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (dp_status.out_free && dp_status.last_pop) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		dp_cmd.op = OP_NONE;
		case (state_q)
			ST_IDLE: begin
				in_ready = dp_status.out_free;
				if (in_valid && dp_status.out_free) begin
					case (cmd)
						CMD_SEND:  dp_cmd.op = OP_SEND;
						CMD_RECV:  dp_cmd.op = dp_status.no_drain ? OP_BELOW : OP_START;
						CMD_RESET: dp_cmd.op = OP_RESET;
						default:   dp_cmd.op = OP_NONE;
					endcase
				end
			end
			ST_DRAIN: begin
				if (dp_status.out_free) begin
					dp_cmd.op = OP_POP;
				end
			end
			default: begin
				dp_cmd.op = OP_NONE;
			end
		endcase
	end

endmodule

[design/bfifo_dp.sv]
module bfifo_dp #(
	parameter int DEPTH = bfifo_pkg::DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic [bfifo_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bfifo_pkg::VAL_W-1:0]       cfg_data,
	input  logic [bfifo_pkg::BYTE_W-1:0]      data_byte,
	input  logic [bfifo_pkg::VAL_W-1:0]       request_length,
	input  bfifo_pkg::dp_cmd_t                dp_cmd,
	output bfifo_pkg::dp_status_t             dp_status,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [bfifo_pkg::KIND_W-1:0]      kind,
	output logic                              accepted,
	output logic [bfifo_pkg::BYTE_W-1:0]      data_out,
	output logic                              last,
	output logic [bfifo_pkg::VAL_W-1:0]       fill_level
);
	import bfifo_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [VAL_W-1:0] DEPTH_V = VAL_W'(DEPTH);
	localparam logic [PTR_W:0]   DEPTH_P = (PTR_W + 1)'(DEPTH);

	logic [BYTE_W-1:0] mem [DEPTH];
	logic [BYTE_W-1:0] rd_data_q;

	logic [VAL_W-1:0] capacity_q;
	logic [VAL_W-1:0] trigger_q;
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] held_q;
	logic [VAL_W-1:0] rem_q;

	logic              out_valid_q;
	kind_t             kind_q;
	logic              accepted_q;
	logic [BYTE_W-1:0] data_out_q;
	logic              last_q;
	logic [VAL_W-1:0]  fill_q;

	logic [VAL_W-1:0] eff_cap;
	logic [VAL_W-1:0] eff_trig;
	logic             can_send;
	logic             wr_en;
	logic [PTR_W-1:0] wr_ptr_adv;
	logic [PTR_W-1:0] rd_ptr_adv;
	logic [PTR_W-1:0] rd_addr_nxt;

	// Step a pointer, wrapping at the effective capacity.
	function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] p,
			input logic [VAL_W-1:0] cap);
		logic [PTR_W:0] n;
		n = {1'b0, p} + (PTR_W + 1)'(1);
		if (VAL_W'(n) >= cap || n >= DEPTH_P) begin
			return '0;
		end
		return n[PTR_W-1:0];
	endfunction

	assign eff_cap  = (capacity_q == '0) ? VAL_W'(1) :
	                  ((capacity_q > DEPTH_V) ? DEPTH_V : capacity_q);
	assign eff_trig = (trigger_q == '0) ? VAL_W'(1) : trigger_q;
	assign can_send = VAL_W'(held_q) < eff_cap;
	assign wr_en    = (dp_cmd.op == OP_SEND) && can_send;

	assign wr_ptr_adv = ptr_adv(wr_ptr_q, eff_cap);
	assign rd_ptr_adv = ptr_adv(rd_ptr_q, eff_cap);

	always_comb begin
		case (dp_cmd.op)
			OP_POP:   rd_addr_nxt = rd_ptr_adv;
			OP_RESET: rd_addr_nxt = '0;
			default:  rd_addr_nxt = rd_ptr_q;
		endcase
	end

	assign dp_status.out_free = !out_valid_q || out_ready;
	assign dp_status.no_drain = (request_length == '0) || (VAL_W'(held_q) < eff_trig);
	assign dp_status.last_pop = (rem_q == VAL_W'(1)) || (held_q == CNT_W'(1));

	// Ring storage. The read port always prefetches the entry at the read
	// pointer of the next cycle, with the write forwarded when they meet.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ptr_q] <= data_byte;
		end
		if (wr_en && wr_ptr_q == rd_addr_nxt) begin
			rd_data_q <= data_byte;
		end else begin
			rd_data_q <= mem[rd_addr_nxt];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RST;
			trigger_q  <= TRIGGER_RST;
		end else if (cfg_valid) begin
			if (cfg_index == REG_CAPACITY) begin
				capacity_q <= cfg_data;
			end else if (cfg_index == REG_TRIGGER) begin
				trigger_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			held_q      <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (dp_cmd.op)
				OP_SEND: begin
					out_valid_q <= 1'b1;
					if (can_send) begin
						wr_ptr_q <= wr_ptr_adv;
						held_q   <= held_q + CNT_W'(1);
					end
				end
				OP_BELOW: begin
					out_valid_q <= 1'b1;
				end
				OP_RESET: begin
					out_valid_q <= 1'b1;
					wr_ptr_q    <= '0;
					rd_ptr_q    <= '0;
					held_q      <= '0;
				end
				OP_START: begin
					rem_q <= request_length;
				end
				OP_POP: begin
					out_valid_q <= 1'b1;
					rd_ptr_q    <= rd_ptr_adv;
					held_q      <= held_q - CNT_W'(1);
					rem_q       <= rem_q - VAL_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		case (dp_cmd.op)
			OP_SEND: begin
				kind_q     <= KIND_SEND;
				accepted_q <= can_send;
				data_out_q <= '0;
				last_q     <= 1'b1;
				fill_q     <= can_send ? VAL_W'(held_q) + VAL_W'(1) : VAL_W'(held_q);
			end
			OP_BELOW: begin
				kind_q     <= KIND_BELOW;
				accepted_q <= 1'b0;
				data_out_q <= '0;
				last_q     <= 1'b1;
				fill_q     <= VAL_W'(held_q);
			end
			OP_RESET: begin
				kind_q     <= KIND_RESET;
				accepted_q <= 1'b0;
				data_out_q <= '0;
				last_q     <= 1'b1;
				fill_q     <= '0;
			end
			OP_POP: begin
				kind_q     <= KIND_BYTE;
				accepted_q <= 1'b0;
				data_out_q <= rd_data_q;
				last_q     <= dp_status.last_pop;
				fill_q     <= VAL_W'(held_q) - VAL_W'(1);
			end
			default: begin
			end
		endcase
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign accepted   = accepted_q;
	assign data_out   = data_out_q;
	assign last       = last_q;
	assign fill_level = fill_q;

	// The fill count never passes the ring depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		VAL_W'(held_q) <= DEPTH_V)
		else $error("fill count exceeds ring depth");

	// A pop is never issued on an empty ring.
	assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.op == OP_POP |-> held_q != '0)
		else $error("pop issued on empty ring");

	// A stalled result is never overwritten by a new operation.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> dp_cmd.op == OP_NONE)
		else $error("result overwritten while stalled");

	// A stored byte raises the fill count by exactly one.
	assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> held_q == $past(held_q) + CNT_W'(1))
		else $error("accepted send did not raise the fill count");

endmodule

[design/byte_fifo_with_trigger_level.sv]
// Byte ring FIFO with a trigger level.
//
// Items arrive on the input channel (in_valid/in_ready) with an operation in
// cmd: send one byte, receive a burst of up to request_length bytes, or empty
// the FIFO. Results leave on the output channel (out_valid/out_ready), one
// beat per result, each carrying the fill level after it and last on the
// final beat of its item. Configuration registers capacity and
// trigger_level are written through the cfg channel, which is always ready.
//
// A send, an empty command or a receive below the trigger (or of length zero)
// answers with one registered beat; a new item is taken every cycle as long
// as the receiver keeps up. A receive burst first loads its length into the
// remaining count, then pops its bytes into the output register while the
// receiver keeps up; the input is not ready until the burst ends.
// The ring read port always prefetches the entry at the next read pointer,
// which lets the bytes stream without gaps. An unused code is taken and
// answers nothing.
//
// Reset clears the pointers, the fill count and the output valid flag and
// restores capacity 64 and trigger level 1; the ring contents are kept.
// When the receiver stalls, the result is held in the output register and
// no further item is accepted until that beat is taken.
module byte_fifo_with_trigger_level #(
	parameter int DEPTH = bfifo_pkg::DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bfifo_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bfifo_pkg::VAL_W-1:0]       cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [bfifo_pkg::CMD_W-1:0]       cmd,
	input  logic [bfifo_pkg::BYTE_W-1:0]      data_byte,
	input  logic [bfifo_pkg::VAL_W-1:0]       request_length,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [bfifo_pkg::KIND_W-1:0]      kind,
	output logic                              accepted,
	output logic [bfifo_pkg::BYTE_W-1:0]      data_out,
	output logic                              last,
	output logic [bfifo_pkg::VAL_W-1:0]       fill_level
);
	import bfifo_pkg::*;

	dp_cmd_t    dp_cmd;
	dp_status_t dp_status;

	// Configuration writes are taken in any cycle; the user must issue them only
	// while the block is idle, which the block itself does not enforce.
	assign cfg_ready = 1'b1;

	// The controller sequences items and bursts.
	bfifo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.dp_status (dp_status),
		.dp_cmd    (dp_cmd)
	);

	// The datapath holds the ring, pointers, registers and result register.
	bfifo_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.data_byte      (data_byte),
		.request_length (request_length),
		.dp_cmd         (dp_cmd),
		.dp_status      (dp_status),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.kind           (kind),
		.accepted       (accepted),
		.data_out       (data_out),
		.last           (last),
		.fill_level     (fill_level)
	);

endmodule
